### hdl/dq_pkg.sv
package dq_pkg;

    // Number of keys the queue can hold.
    localparam int CAPACITY = 16;

    // Width of the internal entry count, able to hold CAPACITY itself.
    localparam int COUNT_W = $clog2(CAPACITY + 1);

    // Field widths fixed by the interface.
    localparam int MODE_W   = 2;
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    // Operation codes.
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 2'd3;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // One command transaction.
    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic signed [KEY_W-1:0] key_in;
    } cmd_t;

    // One result transaction.
    typedef struct packed {
        logic signed [KEY_W-1:0] key_out;
        logic [STATUS_W-1:0]     status;
        logic [OCC_W-1:0]        occupancy;
    } result_t;

    // Per-cell control: where the cell takes its next key from.
    typedef struct packed {
        logic load;
        logic from_left;
        logic from_right;
    } cell_ctrl_t;

endpackage

### hdl/double_ended_queue.sv
// A result appears with done in the cycle after its command is accepted.
// Throughput: one command per cycle; busy stays low.
// Keys sit in a row of cells with the front key always in the first cell.
// Reset clears the entry count and the result strobe; cell contents stay undefined.
// The receiver cannot stall: each result is shown for exactly one cycle.
module double_ended_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  dq_pkg::cmd_t    cmd,
    output logic            done,
    output dq_pkg::result_t result
);

    logic [dq_pkg::COUNT_W-1:0] count_reg;
    logic [dq_pkg::COUNT_W-1:0] count_next;
    logic                       done_reg;
    dq_pkg::result_t            result_reg;
    dq_pkg::result_t            result_next;

    logic                       accept;
    logic                       is_full;
    logic                       is_empty;
    logic                       do_push_front;
    logic                       do_push_back;
    logic                       do_pop_front;
    logic [dq_pkg::COUNT_W-1:0] back_idx;
    logic signed [dq_pkg::KEY_W-1:0] back_key;

    logic signed [dq_pkg::KEY_W-1:0] cell_key [dq_pkg::CAPACITY];
    dq_pkg::cell_ctrl_t              cell_ctrl [dq_pkg::CAPACITY];

    // The block takes a command in every cycle.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Decode the operation against the fill state.
    // A pop from the back only moves the count, so it needs no cell control.
    assign is_full  = (count_reg == dq_pkg::COUNT_W'(dq_pkg::CAPACITY));
    assign is_empty = (count_reg == '0);
    assign do_push_front = accept && (cmd.mode == dq_pkg::MODE_PUSH_FRONT) && !is_full;
    assign do_push_back  = accept && (cmd.mode == dq_pkg::MODE_PUSH_BACK) && !is_full;
    assign do_pop_front  = accept && (cmd.mode == dq_pkg::MODE_POP_FRONT) && !is_empty;
    assign back_idx      = count_reg - dq_pkg::COUNT_W'(1);

    // Row of cells: push front shifts toward the back, pop front toward the front.
    for (genvar i = 0; i < dq_pkg::CAPACITY; i++)
    begin : g_cell
        logic signed [dq_pkg::KEY_W-1:0] left_key;
        logic signed [dq_pkg::KEY_W-1:0] right_key;

        if (i == 0)
        begin : g_first
            assign left_key = cmd.key_in;
        end
        else
        begin : g_inner_left
            assign left_key = cell_key[i-1];
        end

        if (i == dq_pkg::CAPACITY - 1)
        begin : g_last
            assign right_key = cell_key[i];
        end
        else
        begin : g_inner_right
            assign right_key = cell_key[i+1];
        end

        always_comb
        begin
            cell_ctrl[i].load = ((i == 0) && do_push_front)
                || (do_push_back && (count_reg == dq_pkg::COUNT_W'(i)));
            cell_ctrl[i].from_left  = do_push_front && (i != 0);
            cell_ctrl[i].from_right = do_pop_front;
        end

        dq_cell u_cell (
            .clk       (clk),
            .ctrl      (cell_ctrl[i]),
            .new_key   (cmd.key_in),
            .left_key  (left_key),
            .right_key (right_key),
            .key       (cell_key[i])
        );
    end

    // Pick the back key out of the row.
    always_comb
    begin
        back_key = '0;
        for (int i = 0; i < dq_pkg::CAPACITY; i++)
        begin
            if (back_idx == dq_pkg::COUNT_W'(i))
            begin
                back_key = cell_key[i];
            end
        end
    end

    // Next count and the result transaction.
    always_comb
    begin
        count_next = count_reg;
        result_next.key_out = '0;
        result_next.status  = dq_pkg::ST_DONE;
        case (cmd.mode)
            dq_pkg::MODE_PUSH_FRONT, dq_pkg::MODE_PUSH_BACK:
            begin
                if (is_full)
                begin
                    result_next.status = dq_pkg::ST_FULL;
                end
                else
                begin
                    count_next = count_reg + dq_pkg::COUNT_W'(1);
                end
            end
            dq_pkg::MODE_POP_FRONT, dq_pkg::MODE_POP_BACK:
            begin
                if (is_empty)
                begin
                    result_next.status = dq_pkg::ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - dq_pkg::COUNT_W'(1);
                    result_next.key_out = (cmd.mode == dq_pkg::MODE_POP_FRONT) ?
                        cell_key[0] : back_key;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        result_next.occupancy = dq_pkg::OCC_W'(count_next);
    end

    // Control state: entry count and the result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // An accepted command yields its result in the following cycle.
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("result strobe missing after an accepted command");

    // The entry count never exceeds the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= dq_pkg::COUNT_W'(dq_pkg::CAPACITY))
        else $error("entry count beyond capacity");

    // A refused push leaves a full queue behind.
    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status == dq_pkg::ST_FULL)
            |-> (count_reg == dq_pkg::COUNT_W'(dq_pkg::CAPACITY)))
        else $error("full status reported while queue not full");

    // A pop on an empty queue reports a zero key and zero occupancy.
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status == dq_pkg::ST_EMPTY)
            |-> (result.key_out == '0) && (result.occupancy == '0))
        else $error("empty pop returned a key or nonzero occupancy");

endmodule

### hdl/dq_cell.sv
module dq_cell (
    input  logic                              clk,
    input  dq_pkg::cell_ctrl_t                ctrl,
    input  logic signed [dq_pkg::KEY_W-1:0]   new_key,
    input  logic signed [dq_pkg::KEY_W-1:0]   left_key,
    input  logic signed [dq_pkg::KEY_W-1:0]   right_key,
    output logic signed [dq_pkg::KEY_W-1:0]   key
);

    logic signed [dq_pkg::KEY_W-1:0] key_reg;
    logic signed [dq_pkg::KEY_W-1:0] key_next;

    // Select a new key, a neighbor's key, or hold.
    always_comb
    begin
        if (ctrl.load)
        begin
            key_next = new_key;
        end
        else if (ctrl.from_left)
        begin
            key_next = left_key;
        end
        else if (ctrl.from_right)
        begin
            key_next = right_key;
        end
        else
        begin
            key_next = key_reg;
        end
    end

    // Key storage; payload only, so no reset.
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key = key_reg;

endmodule
